// File: src/dcbd_pkg.sv
// Shared types, constants and calendar helpers for the day count block.
`default_nettype none
package dcbd_pkg;

	localparam int unsigned YEAR_W   = 12;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned COUNT_W  = 18;
	localparam int unsigned SERIAL_W = 21;   // serial day number of any 12-bit year
	localparam int unsigned WIDE_W   = 22;   // signed difference before saturation
	localparam int unsigned CENT_W   = 6;    // floor(year / 100)
	localparam int unsigned DOY_W    = 9;    // days before a month

	// floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for every 12-bit x
	localparam int unsigned RECIP_W     = 14;
	localparam int unsigned RECIP_SHIFT = 20;
	localparam logic [RECIP_W-1:0] RECIP_100 = 14'd10486;

	localparam logic [6:0]          YEARS_PER_CENT = 7'd100;
	localparam logic [SERIAL_W-1:0] DAYS_PER_YEAR  = 21'd365;
	localparam logic signed [WIDE_W-1:0] DAYS_360  = 22'sd360;
	localparam logic signed [WIDE_W-1:0] DAYS_30   = 22'sd30;
	localparam logic [MONTH_W-1:0]  MONTH_FEB      = 4'd2;
	localparam logic [DAY_W-1:0]    DAY_28         = 5'd28;
	localparam logic [DAY_W-1:0]    DAY_29         = 5'd29;
	localparam logic [DAY_W-1:0]    DAY_30         = 5'd30;
	localparam logic [DAY_W-1:0]    DAY_31         = 5'd31;

	localparam logic signed [COUNT_W-1:0] COUNT_MAX = 18'sh1ffff;
	localparam logic signed [COUNT_W-1:0] COUNT_MIN = 18'sh20000;

	typedef enum logic {
		MODE_ACTUAL = 1'b0,
		MODE_30_360 = 1'b1
	} mode_t;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
	} date_t;

	// load enables of the three inner pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} pipe_en_t;

	// days before the first of a month in a common year
	function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m);
		logic [DOY_W-1:0] r;
		unique case (m)
			4'd0, 4'd1:        r = 9'd0;
			4'd2:              r = 9'd31;
			4'd3:              r = 9'd59;
			4'd4:              r = 9'd90;
			4'd5:              r = 9'd120;
			4'd6:              r = 9'd151;
			4'd7:              r = 9'd181;
			4'd8:              r = 9'd212;
			4'd9:              r = 9'd243;
			4'd10:             r = 9'd273;
			4'd11:             r = 9'd304;
			4'd12:             r = 9'd334;
			4'd13, 4'd14, 4'd15: r = 9'd365;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// File: src/dcbd_date_pipe.sv
// Three-stage pipeline turning one date into its serial day number and leap flag.
`default_nettype none
module dcbd_date_pipe (
	input  wire logic              clk,
	input  wire dcbd_pkg::pipe_en_t en,
	input  wire dcbd_pkg::date_t   date,
	output dcbd_pkg::date_t        date_s2,
	output logic                   leap_s2,
	output logic [20:0]            serial_s3
);
	import dcbd_pkg::*;

	// stage 1: century by reciprocal multiply
	logic [YEAR_W+RECIP_W-1:0] cent_prod;
	date_t                     date_s1;
	logic [CENT_W-1:0]         cent_s1;

	assign cent_prod = (YEAR_W+RECIP_W)'(date.year) * (YEAR_W+RECIP_W)'(RECIP_100);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			date_s1 <= date;
			cent_s1 <= cent_prod[RECIP_SHIFT +: CENT_W];
		end
	end

	// stage 2: leap rule and leap-day count of the years before
	logic [YEAR_W-1:0] cent_x100;
	logic [6:0]        yr_rem;
	logic              rem_nz;
	logic              leap_c;
	logic [CENT_W-1:0] c100;
	logic [3:0]        c400;
	logic [10:0]       c4;
	logic [12:0]       y_plus3;
	logic [CENT_W:0]   c100_plus3;
	logic [10:0]       ycorr_c;
	logic [10:0]       ycorr_s2;

	always_comb begin
		cent_x100  = YEAR_W'(cent_s1) * YEAR_W'(YEARS_PER_CENT);
		yr_rem     = 7'(date_s1.year - cent_x100);
		rem_nz     = (yr_rem != 7'd0);
		leap_c     = (rem_nz && (date_s1.year[1:0] == 2'd0)) ||
		             (!rem_nz && (cent_s1[1:0] == 2'd0));
		c100       = cent_s1 + CENT_W'(rem_nz);
		c100_plus3 = {1'b0, c100} + 7'd3;
		c400       = 4'(c100_plus3 >> 2);
		y_plus3    = {1'b0, date_s1.year} + 13'd3;
		c4         = 11'(y_plus3 >> 2);
		ycorr_c    = c4 - 11'(c100) + 11'(c400);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			date_s2  <= date_s1;
			leap_s2  <= leap_c;
			ycorr_s2 <= ycorr_c;
		end
	end

	// stage 3: serial day number
	logic [SERIAL_W-1:0] serial_c;

	always_comb begin
		serial_c = SERIAL_W'(date_s2.year) * DAYS_PER_YEAR
		         + SERIAL_W'(ycorr_s2)
		         + SERIAL_W'(month_start(date_s2.month))
		         + SERIAL_W'(leap_s2 && (date_s2.month > MONTH_FEB))
		         + SERIAL_W'(date_s2.day);
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			serial_s3 <= serial_c;
		end
	end

endmodule
`default_nettype wire

// File: src/day_count_between_dates_core.sv
// Top level: signed day count between two dates, actual or 30/360 US.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  cfg      | cfg_valid/cfg_ready  | day_count_mode
//  in       | in_valid/in_stall    | start_year/month/day, end_year/month/day
//  out      | out_valid/out_stall  | day_count
//
//  One date pair per cycle while out is not stalled.
//  Stages: century multiply, leap rule, serial number and 30/360 sum,
//  difference with saturation into the output register.
//  The mode is sampled with each item at entry and travels with it.
//  A stall on out only holds the stages that are full; empty stages keep filling.
//  arst_n clears valid bits and the mode register (actual day count).
`default_nettype none
module day_count_between_dates_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        day_count_mode,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [11:0] start_year,
	input  wire logic [3:0]  start_month,
	input  wire logic [4:0]  start_day,
	input  wire logic [11:0] end_year,
	input  wire logic [3:0]  end_month,
	input  wire logic [4:0]  end_day,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [17:0] day_count
);
	import dcbd_pkg::*;

	// mode register, always writable
	mode_t mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ACTUAL;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= mode_t'(day_count_mode);
		end
	end

	// pipeline control: a stage loads when empty or when the next one moves
	logic     valid_s1, valid_s2, valid_s3;
	logic     en_out;
	logic     en_s1, en_s2, en_s3;
	pipe_en_t en;

	assign en_out   = !out_valid || !out_stall;
	assign en_s3    = !valid_s3 || en_out;
	assign en_s2    = !valid_s2 || en_s3;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;
	assign en       = '{s1: en_s1, s2: en_s2, s3: en_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (en.s1)  valid_s1  <= in_valid;
			if (en.s2)  valid_s2  <= valid_s1;
			if (en.s3)  valid_s3  <= valid_s2;
			if (en_out) out_valid <= valid_s3;
		end
	end

	mode_t mode_s1, mode_s2, mode_s3;

	always_ff @(posedge clk) begin
		if (en.s1) mode_s1 <= mode_q;
		if (en.s2) mode_s2 <= mode_s1;
		if (en.s3) mode_s3 <= mode_s2;
	end

	// per-date serial numbers
	date_t               start_date, end_date;
	date_t               start_s2, end_s2;
	logic                start_leap_s2, end_leap_s2;
	logic [SERIAL_W-1:0] start_serial_s3, end_serial_s3;

	assign start_date = '{year: start_year, month: start_month, day: start_day};
	assign end_date   = '{year: end_year,   month: end_month,   day: end_day};

	dcbd_date_pipe u_start (
		.clk       (clk),
		.en        (en),
		.date      (start_date),
		.date_s2   (start_s2),
		.leap_s2   (start_leap_s2),
		.serial_s3 (start_serial_s3)
	);

	dcbd_date_pipe u_end (
		.clk       (clk),
		.en        (en),
		.date      (end_date),
		.date_s2   (end_s2),
		.leap_s2   (end_leap_s2),
		.serial_s3 (end_serial_s3)
	);

	// 30/360 US: day adjustment then weighted sum, in stage 3
	logic                     feb_end1, feb_end2;
	logic [DAY_W-1:0]         d1_adj, d2_adj;
	logic signed [12:0]       y_diff;
	logic signed [4:0]        m_diff;
	logic signed [5:0]        d_diff;
	logic signed [WIDE_W-1:0] t360_c;
	logic signed [WIDE_W-1:0] t360_s3;

	always_comb begin
		feb_end1 = (start_s2.month == MONTH_FEB) &&
		           (start_s2.day == (start_leap_s2 ? DAY_29 : DAY_28));
		feb_end2 = (end_s2.month == MONTH_FEB) &&
		           (end_s2.day == (end_leap_s2 ? DAY_29 : DAY_28));
		d1_adj = start_s2.day;
		d2_adj = end_s2.day;
		if (feb_end1 && feb_end2) d2_adj = DAY_30;
		if (feb_end1)             d1_adj = DAY_30;
		if ((d2_adj == DAY_31) && (d1_adj >= DAY_30)) d2_adj = DAY_30;
		if (d1_adj == DAY_31)     d1_adj = DAY_30;
		y_diff = $signed({1'b0, end_s2.year})  - $signed({1'b0, start_s2.year});
		m_diff = $signed({1'b0, end_s2.month}) - $signed({1'b0, start_s2.month});
		d_diff = $signed({1'b0, d2_adj})       - $signed({1'b0, d1_adj});
		t360_c = WIDE_W'(y_diff) * DAYS_360
		       + WIDE_W'(m_diff) * DAYS_30
		       + WIDE_W'(d_diff);
	end

	always_ff @(posedge clk) begin
		if (en.s3) t360_s3 <= t360_c;
	end

	// output stage: actual difference, mode select, saturate to 18 bits
	logic signed [WIDE_W-1:0]  actual_diff;
	logic signed [WIDE_W-1:0]  wide_sel;
	logic signed [COUNT_W-1:0] count_c;
	logic signed [COUNT_W-1:0] day_count_q;

	always_comb begin
		actual_diff = $signed({1'b0, end_serial_s3}) - $signed({1'b0, start_serial_s3});
		wide_sel    = (mode_s3 == MODE_30_360) ? t360_s3 : actual_diff;
		if ((&wide_sel[WIDE_W-1:COUNT_W-1]) || !(|wide_sel[WIDE_W-1:COUNT_W-1])) begin
			count_c = wide_sel[COUNT_W-1:0];
		end else if (wide_sel[WIDE_W-1]) begin
			count_c = COUNT_MIN;
		end else begin
			count_c = COUNT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) day_count_q <= count_c;
	end

	assign day_count = day_count_q;

	// checks
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted transfer did not reach stage 1");

	a_full_stall_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && valid_s3 && out_valid && out_stall) |-> in_stall)
		else $error("full pipeline under stall still accepts input");

	a_s3_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && en_out) |=> out_valid)
		else $error("stage 3 item lost on its way out");

	a_s3_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !en_out) |=> (valid_s3 && $stable(t360_s3) && $stable(end_serial_s3)))
		else $error("stalled stage 3 item changed");

endmodule
`default_nettype wire

// File: verif/day_count_between_dates_core_tb.sv
// Testbench for day_count_between_dates_core: directed and random date pairs checked against a calendar predictor.
module day_count_between_dates_core_tb;
	import dcbd_pkg::*;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 6;
	localparam int PIPE_LATENCY = 4;
	localparam int LONG_HOLD    = 300;       // receiver hold-off, long enough to back up the pipe
	localparam int CYCLE_LIMIT  = 200000;
	localparam longint COUNT_HI = 131071;
	localparam longint COUNT_LO = -131072;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic day_count_mode = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic [YEAR_W-1:0]  start_year = '0;
	logic [MONTH_W-1:0] start_month = '0;
	logic [DAY_W-1:0]   start_day = '0;
	logic [YEAR_W-1:0]  end_year = '0;
	logic [MONTH_W-1:0] end_month = '0;
	logic [DAY_W-1:0]   end_day = '0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [COUNT_W-1:0] day_count;

	// mirror of the mode register; only changes between phases when the block is idle
	mode_t active_mode = MODE_ACTUAL;

	// day counts still owed by the block, oldest first
	logic signed [COUNT_W-1:0] expected_day_counts[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_requests = 0;
	int mismatch_count = 0;
	int pairs_sent = 0;
	int counts_checked = 0;
	int input_stall_cycles = 0;
	int cycle_count = 0;

	always #CLK_HALF clk = ~clk;

	day_count_between_dates_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.day_count_mode (day_count_mode),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.start_year     (start_year),
		.start_month    (start_month),
		.start_day      (start_day),
		.end_year       (end_year),
		.end_month      (end_month),
		.end_day        (end_day),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.day_count      (day_count)
	);

	// ---------------------------------------------------------------
	// Calendar predictor
	// ---------------------------------------------------------------

	// Gregorian rule, extended to any year including year 0
	function automatic bit leap_year(input longint y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	// common-year days before the first of month m; month 0 counts nothing,
	// months 13..15 count the whole year
	function automatic longint days_before_month(input logic [MONTH_W-1:0] m);
		case (m)
			4'd0, 4'd1: return 0;
			4'd2:       return 31;
			4'd3:       return 59;
			4'd4:       return 90;
			4'd5:       return 120;
			4'd6:       return 151;
			4'd7:       return 181;
			4'd8:       return 212;
			4'd9:       return 243;
			4'd10:      return 273;
			4'd11:      return 304;
			4'd12:      return 334;
			default:    return 365;
		endcase
	endfunction

	function automatic int month_length(input longint y, input int m);
		case (m)
			2:           return leap_year(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	// days from the start of year 0 up to and including the given date
	function automatic longint serial_day(input date_t d);
		longint y;
		longint n;
		longint dd;
		y = d.year;
		dd = d.day;
		n = y * 365 + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
		n += days_before_month(d.month);
		if (d.month > MONTH_FEB && leap_year(y))
			n++;
		return n + dd;
	endfunction

	function automatic bit feb_last(input date_t d);
		longint dd;
		dd = d.day;
		return (d.month == MONTH_FEB) && (dd == (leap_year(d.year) ? 29 : 28));
	endfunction

	// 30/360 US: Feb month end -> 30 (end date only if start is one too), 31 -> 30 (end date only if start >= 30)
	function automatic longint thirty_360_days(input date_t a, input date_t b);
		longint y1, y2, m1, m2, d1, d2;
		bit a_end;
		bit b_end;
		y1 = a.year;
		y2 = b.year;
		m1 = a.month;
		m2 = b.month;
		d1 = a.day;
		d2 = b.day;
		a_end = feb_last(a);
		b_end = feb_last(b);
		if (a_end && b_end)
			d2 = 30;
		if (a_end)
			d1 = 30;
		if (d2 == 31 && d1 >= 30)
			d2 = 30;
		if (d1 == 31)
			d1 = 30;
		return 360 * (y2 - y1) + 30 * (m2 - m1) + (d2 - d1);
	endfunction

	function automatic logic signed [COUNT_W-1:0] predict_day_count(input mode_t mode,
			input date_t a, input date_t b);
		longint span;
		if (mode == MODE_30_360)
			span = thirty_360_days(a, b);
		else
			span = serial_day(b) - serial_day(a);
		if (span > COUNT_HI)
			span = COUNT_HI;
		if (span < COUNT_LO)
			span = COUNT_LO;
		return span[COUNT_W-1:0];
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------

	function automatic date_t date_of(input int y, input int m, input int d);
		date_t r;
		r.year = y[YEAR_W-1:0];
		r.month = m[MONTH_W-1:0];
		r.day = d[DAY_W-1:0];
		return r;
	endfunction

	// mostly valid dates in 1900..2099 with month ends favored; a few raw field values
	function automatic date_t random_date();
		date_t d;
		int pick;
		int len;
		pick = $urandom_range(99);
		if (pick < 8) begin
			d.year = YEAR_W'($urandom_range(4095));
			d.month = MONTH_W'($urandom_range(15));
			d.day = DAY_W'($urandom_range(31));
		end else begin
			d.year = YEAR_W'($urandom_range(2099, 1900));
			d.month = MONTH_W'($urandom_range(12, 1));
			len = month_length(d.year, d.month);
			if (pick < 30)
				d.day = DAY_W'(len);
			else if (pick < 40)
				d.day = DAY_W'((len >= 30) ? 30 : len);
			else
				d.day = DAY_W'($urandom_range(len, 1));
		end
		return d;
	endfunction

	// Offers one date pair and returns at the edge where it transfers; in_valid
	// stays high so the next call can follow back to back.
	task automatic send_pair(input date_t from_date, input date_t to_date);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		{start_year, start_month, start_day} <= from_date;
		{end_year, end_month, end_day} <= to_date;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) begin
			input_stall_cycles++;
			@(posedge clk);
		end
		expected_day_counts.push_back(predict_day_count(active_mode, from_date, to_date));
		pairs_sent++;
	endtask

	// called in the step of the last transfer; drops valid and drains the pipe
	task automatic finish_phase();
		in_valid <= 1'b0;
		while (expected_day_counts.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_mode(input mode_t mode);
		cfg_valid <= 1'b1;
		day_count_mode <= mode;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		active_mode = mode;
	endtask

	task automatic run_random(input int count);
		date_t from_date;
		date_t to_date;
		for (int i = 0; i < count; i++) begin
			from_date = random_date();
			to_date = random_date();
			// short spans within one year are where the 30/360 rules matter most
			if ($urandom_range(2) == 0)
				to_date.year = from_date.year;
			send_pair(from_date, to_date);
		end
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	task automatic send_directed_pairs();
		send_pair(date_of(1900, 1, 1), date_of(2099, 12, 31));     // full range forward
		send_pair(date_of(2099, 12, 31), date_of(1900, 1, 1));     // full range backward
		send_pair(date_of(2000, 2, 29), date_of(2000, 3, 31));     // leap Feb end to day 31
		send_pair(date_of(1900, 2, 28), date_of(2001, 2, 28));     // both on Feb end
		send_pair(date_of(2024, 1, 31), date_of(2024, 3, 31));     // 31 to 31
		send_pair(date_of(2023, 3, 30), date_of(2023, 5, 31));     // 30 to 31
		send_pair(date_of(2023, 1, 15), date_of(2023, 1, 31));     // 31 end kept
		send_pair(date_of(0, 0, 0), date_of(4095, 15, 31));        // positive saturation
		send_pair(date_of(4095, 15, 31), date_of(0, 0, 0));        // negative saturation
		send_pair(date_of(2021, 13, 0), date_of(2021, 14, 1));     // months past 12, day 0
		send_pair(date_of(1999, 4, 31), date_of(2000, 2, 30));     // days past month end
		send_pair(date_of(2100, 2, 28), date_of(2400, 2, 29));     // century rules outside range
	endtask

	// reset value of the mode first, then the 30/360 setting
	task automatic test_directed();
		send_directed_pairs();
		finish_phase();
		write_mode(MODE_30_360);
		send_directed_pairs();
		finish_phase();
	endtask

	task automatic test_random_actual();
		write_mode(MODE_ACTUAL);
		run_random(350);
		finish_phase();
	endtask

	task automatic test_random_30_360();
		write_mode(MODE_30_360);
		run_random(350);
		finish_phase();
	endtask

	// receiver stalls for a long stretch while items keep coming: the pipe must
	// fill and push back on the input without losing or duplicating a transfer
	task automatic test_back_pressure();
		@(negedge clk);
		hold_requests++;
		@(posedge clk);
		run_random(80);
		finish_phase();
	endtask

	task automatic test_mode_switching();
		for (int k = 0; k < 6; k++) begin
			write_mode(k % 2 == 0 ? MODE_ACTUAL : MODE_30_360);
			run_random(100);
			finish_phase();
		end
	endtask

	// ---------------------------------------------------------------
	// Receiver: random stalls plus one long hold-off on request
	// ---------------------------------------------------------------
	initial begin
		int served;
		served = 0;
		forever begin
			@(posedge clk);
			if (hold_requests != served) begin
				served = hold_requests;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
			out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
		end
	end

	// compare each output transfer with the oldest outstanding prediction
	always @(posedge clk) begin
		logic signed [COUNT_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_day_counts.size() == 0) begin
				$error("day_count: transfer with nothing outstanding, actual %0d", day_count);
				mismatch_count++;
			end else begin
				want = expected_day_counts.pop_front();
				counts_checked++;
				if (day_count !== want) begin
					$error("day_count mismatch: expected %0d, actual %0d", want, day_count);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("day_count_between_dates_core_tb NOT OK");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 19;
		recv_idle_pct = 71;
		test_directed();
		test_random_actual();

		send_idle_pct = 71;
		recv_idle_pct = 19;
		test_random_30_360();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_back_pressure();
		test_mode_switching();

		// nothing may come out once the pipe has drained
		repeat (PIPE_LATENCY * 4) @(posedge clk);
		if (expected_day_counts.size() != 0) begin
			$error("day_count: %0d results never arrived", expected_day_counts.size());
			mismatch_count++;
		end

		$display("Sent %0d date pairs under actual and 30/360 US counting, %0d results checked.",
			pairs_sent, counts_checked);
		$display("Input held off %0d cycles in all, run took %0d cycles.",
			input_stall_cycles, cycle_count);
		if (mismatch_count == 0)
			$display("day_count_between_dates_core_tb OK");
		else
			$display("day_count_between_dates_core_tb NOT OK");
		$finish;
	end

endmodule

// File: filelist.f
src/dcbd_pkg.sv
src/dcbd_date_pipe.sv
src/day_count_between_dates_core.sv
verif/day_count_between_dates_core_tb.sv
